// ===== rtl/lrbc_pkg.sv =====
// package for the link reconnect backoff controller: constants, types, helper functions
`timescale 1ns / 1ps
package lrbc_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned ApChanW = 4;
  localparam int unsigned FailW   = 8;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTimeout   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRetryBase = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRetryMax  = 2'd2;

  localparam logic [TimeW-1:0] TimeoutReset   = 32'd10000;
  localparam logic [TimeW-1:0] RetryBaseReset = 32'd5000;
  localparam logic [TimeW-1:0] RetryMaxReset  = 32'd300000;

  localparam logic [FailW-1:0]   FailSat   = 8'd255;
  localparam logic [ChanW-1:0]   ApChanMax = 8'd13;
  localparam logic [ApChanW-1:0] ApChanDef = 4'd1;

  typedef struct packed {
    logic               issued;
    logic               active;
    logic [ApChanW-1:0] chan;
  } ap_res_t;

  // access point start: out-of-range channel falls back to the default, skip if already up on it
  function automatic ap_res_t ap_start(input logic [ChanW-1:0] ch_in,
                                       input logic ok,
                                       input logic active,
                                       input logic [ApChanW-1:0] chan);
    ap_res_t r;
    logic [ChanW-1:0] ch;
    ch = ch_in;
    if (ch == '0 || ch > ApChanMax) begin
      ch = ChanW'(ApChanDef);
    end
    r.issued = 1'b0;
    r.active = active;
    r.chan   = chan;
    if (!(active && ch == ChanW'(chan))) begin
      r.issued = 1'b1;
      r.active = ok;
      if (ok) begin
        r.chan = ch[ApChanW-1:0];
      end
    end
    return r;
  endfunction

  // base doubled once per failure beyond the first, capped at max
  function automatic logic [TimeW-1:0] backoff(input logic [TimeW-1:0] base,
                                               input logic [TimeW-1:0] max_ms,
                                               input logic [FailW-1:0] fails);
    logic [FailW-1:0]   sh;
    logic [2*TimeW-1:0] wide;
    logic [TimeW-1:0]   res;
    sh   = (fails > FailW'(1)) ? fails - FailW'(1) : '0;
    wide = {{TimeW{1'b0}}, base} << sh[4:0];
    if (base == '0) begin
      res = '0;
    end else if (sh >= FailW'(TimeW) || wide > {{TimeW{1'b0}}, max_ms}) begin
      res = max_ms;
    end else begin
      res = wide[TimeW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/link_reconnect_backoff_controller.sv =====
// link reconnect controller with exponential backoff, top level
`timescale 1ns / 1ps
// Takes one begin or poll item per clock while the output is not stalled and
// returns one result item for each: the item is captured in an input register,
// the whole decision (link edge, attempt timeout, backoff check, attempt
// launch, access point start) is one pass of logic into the result register,
// and the state is updated in that same cycle so the next item follows right
// behind. The pass is set by the backoff shift and compare feeding the
// elapsed-time compare. A full result register that is stalled holds the input
// register, and the input stalls only then. retry_delay_ms is derived from the
// held failure count and the current retry registers. Configuration writes go
// straight into the three timing registers; write them only while idle.
module link_reconnect_backoff_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [lrbc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lrbc_pkg::TimeW-1:0]    cfg_wdata_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [lrbc_pkg::TimeW-1:0]    now_ms_i,
  input  logic                          link_up_i,
  input  logic                          ssid_set_i,
  input  logic [lrbc_pkg::ChanW-1:0]    scan_channel_i,
  input  logic                          ap_ok_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          attempt_started_o,
  output logic                          attempt_failed_o,
  output logic                          link_gained_o,
  output logic                          link_lost_o,
  output logic                          scan_requested_o,
  output logic                          ap_restart_o,
  output logic [lrbc_pkg::ApChanW-1:0]  ap_channel_out_o,
  output logic                          ap_up_o,
  output logic [lrbc_pkg::FailW-1:0]    failure_count_o,
  output logic [lrbc_pkg::TimeW-1:0]    retry_delay_ms_o,
  output logic [lrbc_pkg::ChanW-1:0]    station_channel_out_o
);
  import lrbc_pkg::*;

  // configuration registers
  logic [TimeW-1:0] timeout_q, base_q, max_q;

  // input register
  logic             in_valid_q;
  logic             mode_q, link_q, ssid_q, ok_q;
  logic [TimeW-1:0] now_q;
  logic [ChanW-1:0] scan_q;

  // controller state
  logic               was_linked_q, was_linked_d;
  logic               running_q, running_d;
  logic [TimeW-1:0]   start_time_q, start_time_d;
  logic [TimeW-1:0]   last_time_q, last_time_d;
  logic [FailW-1:0]   fails_q, fails_d;
  logic [1:0]         fails_mod3_q, fails_mod3_d;  // fails_q modulo three
  logic [ChanW-1:0]   router_ch_q, router_ch_d;
  logic               ap_active_q, ap_active_d;
  logic [ApChanW-1:0] ap_chan_q, ap_chan_d;

  // result flags of this pass
  logic started_d, failed_d, gained_d, lost_d, scan_d, ap_d;

  // result register
  logic               out_valid_q;
  logic               started_q, failed_q, gained_q, lost_q, scan_q2, ap_q;

  logic out_ready, advance, in_take;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      base_q    <= RetryBaseReset;
      max_q     <= RetryMaxReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTimeout:   timeout_q <= cfg_wdata_i;
        CfgRetryBase: base_q    <= cfg_wdata_i;
        CfgRetryMax:  max_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q <= mode_i;
      now_q  <= now_ms_i;
      link_q <= link_up_i;
      ssid_q <= ssid_set_i;
      scan_q <= scan_channel_i;
      ok_q   <= ap_ok_i;
    end
  end

  // one decision pass
  always_comb begin
    logic    do_launch;
    logic    do_count;
    ap_res_t ap_r;

    was_linked_d = was_linked_q;
    running_d    = running_q;
    start_time_d = start_time_q;
    last_time_d  = last_time_q;
    fails_d      = fails_q;
    fails_mod3_d = fails_mod3_q;
    router_ch_d  = router_ch_q;
    ap_active_d  = ap_active_q;
    ap_chan_d    = ap_chan_q;
    started_d    = 1'b0;
    failed_d     = 1'b0;
    gained_d     = 1'b0;
    lost_d       = 1'b0;
    scan_d       = 1'b0;
    ap_d         = 1'b0;
    do_launch    = 1'b0;
    do_count     = 1'b0;
    ap_r         = '0;

    if (mode_q) begin
      // begin: access point on channel one, then attempt
      ap_r        = ap_start(ChanW'(ApChanDef), ok_q, ap_active_d, ap_chan_d);
      ap_d        = ap_r.issued;
      ap_active_d = ap_r.active;
      ap_chan_d   = ap_r.chan;
      do_launch   = 1'b1;
    end else if (link_q) begin
      if (!was_linked_q) begin
        gained_d     = 1'b1;
        was_linked_d = 1'b1;
        running_d    = 1'b0;
        fails_d      = '0;
        fails_mod3_d = '0;
      end
    end else if (was_linked_q) begin
      // link dropped: forget the router channel and retry at once
      lost_d       = 1'b1;
      was_linked_d = 1'b0;
      running_d    = 1'b0;
      fails_d      = '0;
      fails_mod3_d = '0;
      router_ch_d  = '0;
      do_launch    = 1'b1;
    end else if (running_q) begin
      if (now_q - start_time_q >= timeout_q) begin
        running_d   = 1'b0;
        failed_d    = 1'b1;
        last_time_d = now_q;
        do_count    = 1'b1;
      end
    end else if (now_q - last_time_q >= backoff(base_q, max_q, fails_q)) begin
      do_launch = 1'b1;
    end

    if (do_launch) begin
      last_time_d = now_q;
      if (!ssid_q) begin
        do_count = 1'b1;
      end else begin
        // scan when channel unknown or on every third failure
        if (router_ch_d == '0 || (fails_d != '0 && fails_mod3_d == 2'd0)) begin
          scan_d = 1'b1;
          if (scan_q != '0) begin
            router_ch_d = scan_q;
          end
        end
        if (router_ch_d != '0) begin
          ap_r = ap_start(router_ch_d, ok_q, ap_active_d, ap_chan_d);
        end else if (!ap_active_d) begin
          ap_r = ap_start(ChanW'(ApChanDef), ok_q, ap_active_d, ap_chan_d);
        end else begin
          ap_r = '{issued: 1'b0, active: ap_active_d, chan: ap_chan_d};
        end
        ap_d         = ap_d | ap_r.issued;
        ap_active_d  = ap_r.active;
        ap_chan_d    = ap_r.chan;
        started_d    = 1'b1;
        running_d    = 1'b1;
        start_time_d = now_q;
      end
    end

    // saturating failure count with its residue kept alongside
    if (do_count && fails_d != FailSat) begin
      fails_d      = fails_d + FailW'(1);
      fails_mod3_d = (fails_mod3_d == 2'd2) ? 2'd0 : fails_mod3_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_linked_q <= 1'b0;
      running_q    <= 1'b0;
      start_time_q <= '0;
      last_time_q  <= '0;
      fails_q      <= '0;
      fails_mod3_q <= '0;
      router_ch_q  <= '0;
      ap_active_q  <= 1'b0;
      ap_chan_q    <= ApChanDef;
    end else if (advance) begin
      was_linked_q <= was_linked_d;
      running_q    <= running_d;
      start_time_q <= start_time_d;
      last_time_q  <= last_time_d;
      fails_q      <= fails_d;
      fails_mod3_q <= fails_mod3_d;
      router_ch_q  <= router_ch_d;
      ap_active_q  <= ap_active_d;
      ap_chan_q    <= ap_chan_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      started_q             <= started_d;
      failed_q              <= failed_d;
      gained_q              <= gained_d;
      lost_q                <= lost_d;
      scan_q2               <= scan_d;
      ap_q                  <= ap_d;
      ap_channel_out_o      <= ap_chan_d;
      ap_up_o               <= ap_active_d;
      failure_count_o       <= fails_d;
      station_channel_out_o <= router_ch_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign attempt_started_o = started_q;
  assign attempt_failed_o  = failed_q;
  assign link_gained_o     = gained_q;
  assign link_lost_o       = lost_q;
  assign scan_requested_o  = scan_q2;
  assign ap_restart_o      = ap_q;
  assign retry_delay_ms_o  = backoff(base_q, max_q, failure_count_o);

  // checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register can take an item");

  a_start_fail_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(attempt_started_o && attempt_failed_o))
    else $error("attempt started and failed in one item");

  a_gained_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && link_gained_o) |->
      (!attempt_started_o && !ap_restart_o && failure_count_o == '0))
    else $error("link gained item carries other activity");

  a_ap_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ap_channel_out_o != '0 && ap_channel_out_o <= ApChanMax[ApChanW-1:0]))
    else $error("access point channel out of range");

  a_lost_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && link_lost_o) |-> (failure_count_o <= FailW'(1)))
    else $error("failure count not cleared on link loss");

endmodule
